[src/osm_pkg.sv]
// osm_pkg: constants, codes and state type for the order-statistic multiset.
// No dependencies; used by order_statistic_multiset_unit.
`timescale 1ns / 1ps
package osm_pkg;
  localparam int CAPACITY = 256;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_FIND   = 3'd2;
  localparam logic [2:0] MODE_KTH    = 3'd3;
  localparam logic [2:0] MODE_RANK   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_KWAIT,
    ST_DONE
  } state_t;

  // signed order mapped onto unsigned compare
  function automatic logic [31:0] order_key(input logic [31:0] v);
    return {~v[31], v[30:0]};
  endfunction
endpackage

[src/order_statistic_multiset_unit.sv]
// order_statistic_multiset_unit: sorted multiset of signed 32-bit values in one RAM.
// Depends on osm_pkg.
`timescale 1ns / 1ps
// Holds up to CAPACITY signed values in descending order in a single-port-write,
// registered-read RAM and serves one operation per input beat: insert, remove,
// find, k-th largest and rank. One item at a time is in work; every beat gives
// exactly one result beat. Find and rank run a binary search, each probe a RAM
// read (ST_PROBE) then a compare (ST_CMP), then a check read (ST_CHK); k-th
// reads one entry (ST_KWAIT); insert and remove also move every stored value
// that must shift one place, by a read (ST_SHIFT_RD) then a write (ST_SHIFT_WR)
// of the same RAM, so their time grows with the number of values moved.
// The result register lets the next beat be accepted while a result waits.
// No clearing pass is needed: only entries below the fill count are used.
module order_statistic_multiset_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [2:0] mode, [34:3] key_value, [43:35] position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [0] hit, [32:1] value_out, [41:33] rank_out,
                                  // [50:42] count, [51] full_res
);
  import osm_pkg::*;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;

  state_t state_r, state_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [8:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt;
  logic             hit_r, hit_nxt, full_r, full_nxt;
  logic [31:0]      val_r, val_nxt;
  logic [8:0]       rank_r, rank_nxt;
  logic             ov_r, ov_nxt;
  logic [55:0]      od_r, od_nxt;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic             accept, cnt_full, kth_ok, srch_more, match, ins_cont, rem_cont;
  logic             rem_go;
  logic             greater, out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_free  = !ov_r || out_tready;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[CNT_W:1];
  assign cnt_full  = ({1'b0, cnt_r} >= (CNT_W+1)'(CAPACITY));
  assign kth_ok    = (pos_nxt != 9'd0) && (32'(pos_nxt) <= 32'(cnt_r));
  assign srch_more = (lo_r < hi_r);
  assign greater   = order_key(rdata_r) > order_key(key_r);
  assign match     = (rdata_r == key_r);
  // insert: more moves while next j still above the slot
  assign ins_cont  = (CNT_W'(j_r - CNT_W'(1)) != lo_r);
  // remove: more moves while j+2 < count
  assign rem_cont  = ({1'b0, j_r} + (CNT_W+1)'(2)) < {1'b0, cnt_r};
  // remove: any value below the hit slot to move up at all
  assign rem_go    = ({1'b0, j_r} + (CNT_W+1)'(1)) < {1'b0, cnt_r};

  // RAM
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_tdata[2:0])
            MODE_INSERT: state_nxt = cnt_full ? ST_DONE : ST_PROBE;
            MODE_REMOVE, MODE_FIND, MODE_RANK: state_nxt = ST_PROBE;
            MODE_KTH: state_nxt = kth_ok ? ST_KWAIT : ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PROBE: begin
        if (srch_more) begin
          state_nxt = ST_CMP;
        end else if (mode_r == MODE_INSERT) begin
          state_nxt = (cnt_r == lo_r) ? ST_PLACE : ST_SHIFT_RD;
        end else begin
          state_nxt = (lo_r < cnt_r) ? ST_CHK : ST_DONE;
        end
      end
      ST_CMP: state_nxt = ST_PROBE;
      ST_CHK: begin
        if (match && mode_r == MODE_REMOVE && rem_go) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (mode_r == MODE_INSERT) begin
          state_nxt = ins_cont ? ST_SHIFT_RD : ST_PLACE;
        end else begin
          state_nxt = rem_cont ? ST_SHIFT_RD : ST_DONE;
        end
      end
      ST_PLACE: state_nxt = ST_DONE;
      ST_KWAIT: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    mode_nxt = mode_r;
    key_nxt  = key_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    j_nxt    = j_r;
    hit_nxt  = hit_r;
    full_nxt = full_r;
    val_nxt  = val_r;
    rank_nxt = rank_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    we = 1'b0;
    wa = '0;
    wd = key_r;
    ra = mid[AW-1:0];
    if (state_r == ST_IDLE) begin
      pos_nxt = in_tdata[43:35];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = in_tdata[2:0];
          key_nxt  = in_tdata[34:3];
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          hit_nxt  = 1'b0;
          val_nxt  = '0;
          rank_nxt = '0;
          full_nxt = (in_tdata[2:0] == MODE_INSERT) && cnt_full;
          ra       = AW'(32'(in_tdata[43:35]) - 32'd1);
        end
      end
      ST_PROBE: begin
        ra = mid[AW-1:0];
        if (!srch_more) begin
          ra    = lo_r[AW-1:0];
          j_nxt = (mode_r == MODE_INSERT) ? cnt_r : lo_r;
        end
      end
      ST_CMP: begin
        if (greater) begin
          lo_nxt = CNT_W'(mid + CNT_W'(1));
        end else begin
          hi_nxt = mid;
        end
      end
      ST_CHK: begin
        if (match) begin
          hit_nxt = 1'b1;
          if (mode_r == MODE_RANK) begin
            rank_nxt = 9'(32'(lo_r) + 32'd1);
          end
          if (mode_r == MODE_REMOVE && !rem_go) begin
            cnt_nxt = CNT_W'(cnt_r - CNT_W'(1));
          end
        end
      end
      ST_SHIFT_RD: begin
        if (mode_r == MODE_INSERT) begin
          ra = AW'(j_r - CNT_W'(1));
        end else begin
          ra = AW'(j_r + CNT_W'(1));
        end
      end
      ST_SHIFT_WR: begin
        we = 1'b1;
        wa = j_r[AW-1:0];
        wd = rdata_r;
        if (mode_r == MODE_INSERT) begin
          j_nxt = CNT_W'(j_r - CNT_W'(1));
        end else begin
          j_nxt = CNT_W'(j_r + CNT_W'(1));
          if (!rem_cont) begin
            cnt_nxt = CNT_W'(cnt_r - CNT_W'(1));
          end
        end
      end
      ST_PLACE: begin
        we      = 1'b1;
        wa      = lo_r[AW-1:0];
        wd      = key_r;
        cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
        hit_nxt = 1'b1;
      end
      ST_KWAIT: begin
        hit_nxt = 1'b1;
        val_nxt = rdata_r;
      end
      ST_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {4'd0, full_r, 9'(cnt_r), rank_r, val_r, hit_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    j_r    <= j_nxt;
    hit_r  <= hit_nxt;
    full_r <= full_nxt;
    val_r  <= val_nxt;
    rank_r <= rank_nxt;
    od_r   <= od_nxt;
  end
endmodule
